/* hdl/pwbft_pkg.sv */
// Shared types and constants for the pulse-width bus frame transmitter.
// No dependencies; the top level and the sequencer import this package.
`timescale 1ns / 1ps

package pwbft_pkg;

  // Default and limits for the long-frame data length
  localparam int DEF_MAX_DATA_BITS = 32;
  localparam int SHORT_DATA_BITS   = 16;

  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TICKS  = 2'd2;

  // Frames above this value carry the long-length bit
  localparam logic [31:0] SHORT_FRAME_MAX = 32'h0000_FFFF;

  localparam logic [TICK_W-1:0] RST_START_TICKS = 16'd6;
  localparam logic [TICK_W-1:0] RST_ONE_TICKS   = 16'd4;
  localparam logic [TICK_W-1:0] RST_ZERO_TICKS  = 16'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_ticks;
    logic [TICK_W-1:0] one_ticks;
    logic [TICK_W-1:0] zero_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } result_t;

endpackage

/* hdl/pwbft_if.sv */
// Valid/ready channel interfaces for request items and result items.
// Depends on nothing but the port widths of the transmitter.
`timescale 1ns / 1ps

interface pwbft_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] frame_data;

  modport source (output valid, output func, output frame_data, input ready);
  modport sink   (input valid, input func, input frame_data, output ready);
endinterface

interface pwbft_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res,
                  output accepted, output frame_done, input ready);
  modport sink   (input valid, input line_level, input busy_res,
                  input accepted, input frame_done, output ready);
endinterface

/* hdl/pulse_width_bus_frame_transmitter.sv */
// Top level of the pulse-width bus frame transmitter: handshake, result register
// and configuration registers. Depends on pwbft_pkg, pwbft_if.sv, pwbft_sequencer.
//
// Usage:
//   item   - request channel (sink). func = 0 is one elapsed tick, func = 1 asks
//            to send frame_data. A send while a frame is running is dropped and
//            answered with accepted = 0.
//   result - one result per request: line level, busy flag, accepted and
//            frame_done as they stand after that request.
//   cfg_we / cfg_index / cfg_data - write port for start_ticks (0), one_ticks (1)
//            and zero_ticks (2); other indexes are ignored. A value of 0 acts as 1.
// Latency: a result is valid the cycle after its request is taken.
// Throughput: one request per cycle while no result stalls; the state update is a
//   single pass of logic between the sequencer registers, and the only buffer is
//   the one result register.
// Stall: while the result register holds an untaken result, item.ready falls
//   and no request is taken; it rises again in the cycle the result is taken.
// Reset: rst (synchronous) returns the line low and idle, empties the result
//   register and restores the register defaults 6, 4 and 2.
`timescale 1ns / 1ps

module pulse_width_bus_frame_transmitter
  import pwbft_pkg::*;
#(
  parameter int MAX_DATA_BITS = DEF_MAX_DATA_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  pwbft_req_if.sink            item,
  pwbft_res_if.source          result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  cfg_t    cfg;
  result_t res_next;
  result_t res_q;
  logic    out_valid;
  logic    take;

  assign item.ready = !out_valid || result.ready;
  assign take       = item.valid && item.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_ticks <= RST_START_TICKS;
      cfg.one_ticks   <= RST_ONE_TICKS;
      cfg.zero_ticks  <= RST_ZERO_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_TICKS: cfg.start_ticks <= cfg_data;
        REG_ONE_TICKS:   cfg.one_ticks   <= cfg_data;
        REG_ZERO_TICKS:  cfg.zero_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  pwbft_sequencer #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (take),
    .func      (item.func),
    .frame_data(item.frame_data),
    .cfg       (cfg),
    .res       (res_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q <= res_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.line_level = res_q.line_level;
  assign result.busy_res   = res_q.busy_res;
  assign result.accepted   = res_q.accepted;
  assign result.frame_done = res_q.frame_done;

  // Checks
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |=> out_valid && $stable(res_q))
    else $error("stalled result changed");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("taken request left no result");

  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !take)
    else $error("request taken while result stalled");

endmodule

/* hdl/pwbft_sequencer.sv */
// Symbol sequencer: frame state registers and the per-request next-state logic.
// Depends on pwbft_pkg.
`timescale 1ns / 1ps

module pwbft_sequencer
  import pwbft_pkg::*;
#(
  parameter int MAX_DATA_BITS = DEF_MAX_DATA_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        func,
  input  logic [31:0] frame_data,
  input  cfg_t        cfg,
  output result_t     res
);

  localparam int BL_W = $clog2(MAX_DATA_BITS + 2);

  phase_t                   phase, phase_next;
  logic                     line_reg, line_reg_next;
  logic [MAX_DATA_BITS-1:0] shift_data, shift_data_next;
  logic [BL_W-1:0]          bits_left, bits_left_next;
  logic [TICK_W-1:0]        tick_countdown, tick_countdown_next;
  logic                     parity_acc, parity_acc_next;
  logic                     long_frame, long_frame_next;
  logic                     acc, done;
  logic                     data_bit;
  logic                     is_long;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      line_reg       <= 1'b0;
      shift_data     <= '0;
      bits_left      <= '0;
      tick_countdown <= '0;
      parity_acc     <= 1'b1;
      long_frame     <= 1'b0;
    end else begin
      phase          <= phase_next;
      line_reg       <= line_reg_next;
      shift_data     <= shift_data_next;
      bits_left      <= bits_left_next;
      tick_countdown <= tick_countdown_next;
      parity_acc     <= parity_acc_next;
      long_frame     <= long_frame_next;
    end
  end

  assign is_long  = frame_data > SHORT_FRAME_MAX;
  assign data_bit = shift_data[MAX_DATA_BITS-1];

  // Next state: start a frame, count down a symbol, or move to the next symbol
  always_comb begin
    phase_next          = phase;
    line_reg_next       = line_reg;
    shift_data_next     = shift_data;
    bits_left_next      = bits_left;
    tick_countdown_next = tick_countdown;
    parity_acc_next     = parity_acc;
    long_frame_next     = long_frame;
    acc                 = 1'b0;
    done                = 1'b0;
    if (step) begin
      if (func) begin
        // send while busy is dropped without a tick
        if (phase == PH_IDLE) begin
          long_frame_next     = is_long;
          shift_data_next     = is_long ? frame_data[MAX_DATA_BITS-1:0]
                              : (MAX_DATA_BITS'(frame_data[SHORT_DATA_BITS-1:0])
                                 << (MAX_DATA_BITS - SHORT_DATA_BITS));
          bits_left_next      = is_long ? BL_W'(MAX_DATA_BITS + 1)
                                        : BL_W'(SHORT_DATA_BITS + 1);
          parity_acc_next     = 1'b1;
          line_reg_next       = 1'b1;
          tick_countdown_next = cfg.start_ticks;
          phase_next          = PH_START;
          acc                 = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        if (tick_countdown > TICK_W'(1)) begin
          tick_countdown_next = tick_countdown - TICK_W'(1);
        end else begin
          case (phase)
            PH_START: begin
              line_reg_next       = ~line_reg;
              tick_countdown_next = long_frame ? cfg.one_ticks : cfg.zero_ticks;
              phase_next          = PH_LEN;
            end
            PH_LEN, PH_DATA: begin
              phase_next = PH_DATA;
              if (bits_left > BL_W'(1)) begin
                shift_data_next     = shift_data << 1;
                parity_acc_next     = parity_acc ^ data_bit;
                bits_left_next      = bits_left - BL_W'(1);
                line_reg_next       = ~line_reg;
                tick_countdown_next = data_bit ? cfg.one_ticks : cfg.zero_ticks;
              end else if (bits_left == BL_W'(1)) begin
                // parity symbol
                bits_left_next      = '0;
                line_reg_next       = ~line_reg;
                tick_countdown_next = parity_acc ? cfg.one_ticks : cfg.zero_ticks;
              end else begin
                line_reg_next       = 1'b0;
                phase_next          = PH_IDLE;
                tick_countdown_next = '0;
                done                = 1'b1;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end
  end

  assign res.line_level = line_reg_next;
  assign res.busy_res   = phase_next != PH_IDLE;
  assign res.accepted   = acc;
  assign res.frame_done = done;

  // Checks
  a_idle_line_low: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !line_reg)
    else $error("line high while idle");

  a_busy_send_no_effect: assert property (@(posedge clk) disable iff (rst)
    step && func && phase != PH_IDLE |=>
      $stable(shift_data) && $stable(tick_countdown) && $stable(line_reg))
    else $error("send while busy changed frame state");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> phase == PH_IDLE && !line_reg)
    else $error("frame end did not return to idle");

  a_bits_in_range: assert property (@(posedge clk) disable iff (rst)
    bits_left <= BL_W'(MAX_DATA_BITS + 1))
    else $error("bit count out of range");

endmodule
